[design/salsa20_xor_core_defines.svh]
// ----------------------------------------------------------------------------
// salsa20_xor_core_defines.svh
// Assertion macros used by the Salsa20 XOR core RTL.
// ----------------------------------------------------------------------------
`ifndef SALSA20_XOR_CORE_DEFINES_SVH
`define SALSA20_XOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define S20X_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s20x assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define S20X_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s20x assertion failed");

`endif

[design/s20x_pkg.sv]
// ----------------------------------------------------------------------------
// s20x_pkg
// Types, constants and index tables for the Salsa20 XOR core.
// ----------------------------------------------------------------------------
`default_nettype none

package s20x_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int IDX_W       = 4;
  localparam int DRC_W       = 4;
  localparam int QR_W        = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DRC_W-1:0]  drc_t;
  typedef logic [QR_W-1:0]   qr_t;

  localparam idx_t LAST_IDX  = idx_t'(BLOCK_WORDS - 1);
  localparam drc_t DRC_RESET = drc_t'(4);
  localparam qr_t  LAST_QR   = qr_t'(7);

  // Rotate amount of the shared add-rotate-XOR step.
  typedef enum logic [1:0] {
    ROT7  = 2'd0,
    ROT9  = 2'd1,
    ROT13 = 2'd2,
    ROT18 = 2'd3
  } rot_t;

  // Matrix position of block word k (diagonal layout).
  localparam idx_t LAYOUT [BLOCK_WORDS] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd12, 4'd1, 4'd6, 4'd11,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd4, 4'd9, 4'd14, 4'd3
  };

  // Quarter-round lanes: four columns, then four rows.
  localparam idx_t LANES [8][4] = '{
    '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11},
    '{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
    '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  function automatic idx_t layout_pos(input idx_t k);
    return LAYOUT[k];
  endfunction

  function automatic idx_t lane_pos(input qr_t q, input logic [1:0] slot);
    return LANES[q][slot];
  endfunction

endpackage

`default_nettype wire

[design/s20x_stream_if.sv]
// ----------------------------------------------------------------------------
// s20x_stream_if
// Valid/ready channels for the word-pair input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface s20x_in_if;
  logic                  valid;
  logic                  ready;
  s20x_pkg::word_t       dst_word;
  s20x_pkg::word_t       src_word;
  logic                  last_in;

  modport source (output valid, output dst_word, output src_word, output last_in,
                  input ready);
  modport sink   (input valid, input dst_word, input src_word, input last_in,
                  output ready);
endinterface

interface s20x_out_if;
  logic                  valid;
  logic                  ready;
  s20x_pkg::word_t       out_word;
  logic                  last_out;

  modport source (output valid, output out_word, output last_out, input ready);
  modport sink   (input valid, input out_word, input last_out, output ready);
endinterface

`default_nettype wire

[design/salsa20_xor_core.sv]
// A block is loaded at one word pair per cycle while the source offers one; a short
// block then has its missing words zeroed. Each double round runs 8 quarter rounds in
// turn on the one add-rotate-XOR unit, each reading its lane words and then making
// its dependent steps. Each result word is then read from state memory, added and held
// until the output register is free; no new block is taken until the last is handed over.
// Reset (rst_n low, synchronous) clears the control state and sets the count to 4.
// ----------------------------------------------------------------------------
// salsa20_xor_core
// Salsa20 XOR core: XORs a loaded word pair block, runs double rounds, adds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "salsa20_xor_core_defines.svh"

module salsa20_xor_core (
  input  wire                          clk,
  input  wire                          rst_n,
  s20x_in_if.sink                      in_ch,
  s20x_out_if.source                   out_ch,
  input  wire                          cfg_we,
  input  wire [s20x_pkg::DRC_W-1:0]    cfg_wdata
);

  typedef enum logic [4:0] {
    S_LOAD    = 5'b00001,
    S_ZERO    = 5'b00010,
    S_ROUND   = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_LD = 5'b10000
  } state_t;

  typedef logic [2:0] phase_t;

  // Phases of one quarter round.
  localparam phase_t PH_RD_AD  = 3'd0;
  localparam phase_t PH_RD_BC  = 3'd1;
  localparam phase_t PH_STEP_B = 3'd2;
  localparam phase_t PH_STEP_C = 3'd3;
  localparam phase_t PH_STEP_D = 3'd4;
  localparam phase_t PH_STEP_A = 3'd5;

  state_t                state_r, state_nxt;
  s20x_pkg::idx_t        wc_r, wc_nxt;
  s20x_pkg::idx_t        idx_r, idx_nxt;
  s20x_pkg::drc_t        dr_r, dr_nxt;
  s20x_pkg::qr_t         qr_r, qr_nxt;
  phase_t                ph_r, ph_nxt;
  s20x_pkg::drc_t        drc_r;
  s20x_pkg::word_t       lane_r [4];
  s20x_pkg::word_t       lane_nxt [4];
  s20x_pkg::word_t       xored_r [s20x_pkg::BLOCK_WORDS];
  logic                  out_valid_r, out_valid_nxt;
  s20x_pkg::word_t       out_word_r, out_word_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_accept;
  logic                  out_load;
  s20x_pkg::word_t       x_word;
  logic                  xw_en;
  s20x_pkg::idx_t        xw_idx;
  s20x_pkg::word_t       xw_data;

  logic                  ram_we;
  s20x_pkg::idx_t        ram_waddr;
  s20x_pkg::word_t       ram_wdata;
  s20x_pkg::idx_t        ram_raddr0;
  s20x_pkg::idx_t        ram_raddr1;
  s20x_pkg::word_t       ram_rdata0;
  s20x_pkg::word_t       ram_rdata1;

  s20x_pkg::word_t       st_t;
  s20x_pkg::word_t       st_a;
  s20x_pkg::word_t       st_b;
  s20x_pkg::rot_t        st_rot;
  s20x_pkg::word_t       st_y;

  // Handshake and port drive.
  assign in_ch.ready     = (state_r == S_LOAD);
  assign in_accept       = in_ch.valid && in_ch.ready;
  assign x_word          = in_ch.dst_word ^ in_ch.src_word;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_word = out_word_r;
  assign out_ch.last_out = out_last_r;

  // Round state memory and the shared step unit.
  s20x_matrix_ram u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (ram_raddr1),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  s20x_qr_step u_step (
    .t_word (st_t),
    .a_word (st_a),
    .b_word (st_b),
    .rot    (st_rot),
    .y_word (st_y)
  );

  // Sequencer: load, zero fill, quarter-round phases, and result emission.
  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    idx_nxt       = idx_r;
    dr_nxt        = dr_r;
    qr_nxt        = qr_r;
    ph_nxt        = ph_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_load      = 1'b0;
    xw_en         = 1'b0;
    xw_idx        = idx_r;
    xw_data       = '0;
    ram_we        = 1'b0;
    ram_waddr     = s20x_pkg::layout_pos(idx_r);
    ram_wdata     = '0;
    ram_raddr0    = s20x_pkg::layout_pos(idx_r);
    ram_raddr1    = s20x_pkg::lane_pos(qr_r, 2'd3);
    st_t          = lane_r[0];
    st_a          = lane_r[3];
    st_b          = lane_r[2];
    st_rot        = s20x_pkg::ROT18;

    case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          xw_en     = 1'b1;
          xw_idx    = wc_r;
          xw_data   = x_word;
          ram_we    = 1'b1;
          ram_waddr = s20x_pkg::layout_pos(wc_r);
          ram_wdata = x_word;
          if (in_ch.last_in || (wc_r == s20x_pkg::LAST_IDX)) begin
            wc_nxt = '0;
            if (wc_r == s20x_pkg::LAST_IDX) begin
              idx_nxt   = '0;
              qr_nxt    = '0;
              ph_nxt    = PH_RD_AD;
              dr_nxt    = '0;
              state_nxt = (drc_r == '0) ? S_EMIT_RD : S_ROUND;
            end else begin
              idx_nxt   = wc_r + s20x_pkg::idx_t'(1);
              state_nxt = S_ZERO;
            end
          end else begin
            wc_nxt = wc_r + s20x_pkg::idx_t'(1);
          end
        end
      end

      // Short block: clear the words that never arrived.
      S_ZERO: begin
        xw_en  = 1'b1;
        ram_we = 1'b1;
        if (idx_r == s20x_pkg::LAST_IDX) begin
          idx_nxt   = '0;
          qr_nxt    = '0;
          ph_nxt    = PH_RD_AD;
          dr_nxt    = '0;
          state_nxt = (drc_r == '0) ? S_EMIT_RD : S_ROUND;
        end else begin
          idx_nxt = idx_r + s20x_pkg::idx_t'(1);
        end
      end

      // One quarter round: the a and d reads, then the b and c reads, then four dependent steps.
      S_ROUND: begin
        case (ph_r)
          PH_RD_AD: begin
            ram_raddr0 = s20x_pkg::lane_pos(qr_r, 2'd0);
            ram_raddr1 = s20x_pkg::lane_pos(qr_r, 2'd3);
            ph_nxt     = PH_RD_BC;
          end
          PH_RD_BC: begin
            lane_nxt[0] = ram_rdata0;
            lane_nxt[3] = ram_rdata1;
            ram_raddr0  = s20x_pkg::lane_pos(qr_r, 2'd1);
            ram_raddr1  = s20x_pkg::lane_pos(qr_r, 2'd2);
            ph_nxt      = PH_STEP_B;
          end
          PH_STEP_B: begin
            st_t        = ram_rdata0;
            st_a        = lane_r[0];
            st_b        = lane_r[3];
            st_rot      = s20x_pkg::ROT7;
            ram_we      = 1'b1;
            ram_waddr   = s20x_pkg::lane_pos(qr_r, 2'd1);
            ram_wdata   = st_y;
            lane_nxt[1] = st_y;
            lane_nxt[2] = ram_rdata1;
            ph_nxt      = PH_STEP_C;
          end
          PH_STEP_C: begin
            st_t        = lane_r[2];
            st_a        = lane_r[1];
            st_b        = lane_r[0];
            st_rot      = s20x_pkg::ROT9;
            ram_we      = 1'b1;
            ram_waddr   = s20x_pkg::lane_pos(qr_r, 2'd2);
            ram_wdata   = st_y;
            lane_nxt[2] = st_y;
            ph_nxt      = PH_STEP_D;
          end
          PH_STEP_D: begin
            st_t        = lane_r[3];
            st_a        = lane_r[2];
            st_b        = lane_r[1];
            st_rot      = s20x_pkg::ROT13;
            ram_we      = 1'b1;
            ram_waddr   = s20x_pkg::lane_pos(qr_r, 2'd3);
            ram_wdata   = st_y;
            lane_nxt[3] = st_y;
            ph_nxt      = PH_STEP_A;
          end
          PH_STEP_A: begin
            st_t        = lane_r[0];
            st_a        = lane_r[3];
            st_b        = lane_r[2];
            st_rot      = s20x_pkg::ROT18;
            ram_we      = 1'b1;
            ram_waddr   = s20x_pkg::lane_pos(qr_r, 2'd0);
            ram_wdata   = st_y;
            lane_nxt[0] = st_y;
            ph_nxt      = PH_RD_AD;
            qr_nxt      = qr_r + s20x_pkg::qr_t'(1);
            if (qr_r == s20x_pkg::LAST_QR) begin
              if (dr_r == drc_r - s20x_pkg::drc_t'(1)) begin
                idx_nxt   = '0;
                state_nxt = S_EMIT_RD;
              end else begin
                dr_nxt = dr_r + s20x_pkg::drc_t'(1);
              end
            end
          end
          default: begin
            ph_nxt = PH_RD_AD;
          end
        endcase
      end

      // Read the final state word for result idx.
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end

      // Add the stored word and hand it to the output register when free.
      S_EMIT_LD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = xored_r[idx_r] + ram_rdata0;
          out_last_nxt  = (idx_r == s20x_pkg::LAST_IDX);
          if (idx_r == s20x_pkg::LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + s20x_pkg::idx_t'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      wc_r        <= '0;
      idx_r       <= '0;
      dr_r        <= '0;
      qr_r        <= '0;
      ph_r        <= PH_RD_AD;
      drc_r       <= s20x_pkg::DRC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      idx_r       <= idx_nxt;
      dr_r        <= dr_nxt;
      qr_r        <= qr_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        drc_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: lane words, stored XOR block and result word.
  always_ff @(posedge clk) begin
    lane_r       <= lane_nxt;
    out_word_r   <= out_word_nxt;
    out_last_r   <= out_last_nxt;
    if (xw_en) begin
      xored_r[xw_idx] <= xw_data;
    end
  end

  // A completing transaction always leaves the load state.
  `S20X_ASSERT_NEXT(a_block_done,
    in_accept && (in_ch.last_in || (wc_r == s20x_pkg::LAST_IDX)),
    state_r != S_LOAD)
  // The sixteenth result returns the block to loading.
  `S20X_ASSERT_NEXT(a_emit_done,
    out_load && (idx_r == s20x_pkg::LAST_IDX),
    (state_r == S_LOAD) && out_valid_r && out_last_r)
  // The phase counter never leaves the six quarter-round phases.
  `S20X_ASSERT_SAME(a_phase_range, state_r == S_ROUND, ph_r <= PH_STEP_A)
  // The load counter stays cleared outside the load state.
  `S20X_ASSERT_SAME(a_wc_clear, state_r != S_LOAD, wc_r == '0)

endmodule

`default_nettype wire

[design/s20x_qr_step.sv]
// ----------------------------------------------------------------------------
// s20x_qr_step
// Shared add-rotate-XOR unit: y = t ^ rotl(a + b, n), n in {7, 9, 13, 18}.
// ----------------------------------------------------------------------------
`default_nettype none

module s20x_qr_step (
  input  wire s20x_pkg::word_t t_word,
  input  wire s20x_pkg::word_t a_word,
  input  wire s20x_pkg::word_t b_word,
  input  wire s20x_pkg::rot_t  rot,
  output s20x_pkg::word_t      y_word
);

  s20x_pkg::word_t sum;
  s20x_pkg::word_t rotated;

  // Modular add, then a fixed rotate picked by the sequencer.
  always_comb begin
    sum = a_word + b_word;
    case (rot)
      s20x_pkg::ROT7:  rotated = {sum[24:0], sum[31:25]};
      s20x_pkg::ROT9:  rotated = {sum[22:0], sum[31:23]};
      s20x_pkg::ROT13: rotated = {sum[18:0], sum[31:19]};
      s20x_pkg::ROT18: rotated = {sum[13:0], sum[31:14]};
      default:         rotated = sum;
    endcase
    y_word = t_word ^ rotated;
  end

endmodule

`default_nettype wire

[design/s20x_matrix_ram.sv]
// ----------------------------------------------------------------------------
// s20x_matrix_ram
// Sixteen-word round state memory, one write port and two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module s20x_matrix_ram (
  input  wire                   clk,
  input  wire                   we,
  input  wire s20x_pkg::idx_t   waddr,
  input  wire s20x_pkg::word_t  wdata,
  input  wire s20x_pkg::idx_t   raddr0,
  input  wire s20x_pkg::idx_t   raddr1,
  output s20x_pkg::word_t       rdata0,
  output s20x_pkg::word_t       rdata1
);

  s20x_pkg::word_t mem [s20x_pkg::BLOCK_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

[bench/salsa20_xor_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// salsa20_xor_core_tb
// Self-checking bench for the Salsa20 XOR core. A directed table covers the
// round count extremes, short and full blocks and the all-zero block. It is
// followed by random blocks under random round counts. Every result word is
// checked against a typed value or a built-in Salsa20 predictor; channels idle at random.
// ----------------------------------------------------------------------------

module salsa20_xor_core_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_GAP       = 64;
  localparam int DRAIN_CYCLES   = 100;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_WORDS   = 72;
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 23;

  // Matrix position of block word k, and the quarter-round lanes.
  localparam int DIAG [16] = '{0, 5, 10, 15, 12, 1, 6, 11, 8, 13, 2, 7, 4, 9, 14, 3};
  localparam int QLANE [8][4] = '{
    '{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11},
    '{0, 1, 2, 3},  '{5, 6, 7, 4},  '{10, 11, 8, 9}, '{15, 12, 13, 14}
  };

  typedef struct packed {
    s20x_pkg::word_t word;
    logic            last;
  } result_t;

  typedef struct {
    bit              do_cfg;
    s20x_pkg::drc_t  cfg_val;
    s20x_pkg::word_t dst;
    s20x_pkg::word_t src;
    logic            last;
    bit              typed;
    s20x_pkg::word_t typed0;
  } stim_row_t;

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  s20x_pkg::drc_t cfg_wdata;

  s20x_in_if  in_if ();
  s20x_out_if out_if ();

  salsa20_xor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: stored XOR words, fill level and the round count.
  s20x_pkg::word_t xor_store [16];
  int              load_count;
  s20x_pkg::drc_t  round_setting;
  result_t         block_results [$];

  int          error_count;
  int          words_loaded;
  int          blocks_done;
  int          results_checked;
  int          holds_done;
  int          idle_cycles;
  logic [15:0] settings_seen;
  int          sender_gap_max;
  int          receiver_stall_max;
  bit          hold_outputs_request;

  stim_row_t directed_rows [DIRECTED_ROWS];

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic s20x_pkg::word_t rotl(input s20x_pkg::word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic s20x_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Takes one accepted word pair. When the block completes, the Salsa20 rounds
  // are run and sixteen result words are queued. Typed rows queue the word
  // given in the table followed by zeros.
  task automatic absorb_word(input s20x_pkg::word_t d, input s20x_pkg::word_t s,
                             input logic l, input bit typed,
                             input s20x_pkg::word_t typed0);
    s20x_pkg::word_t m [16];
    int              a, b, c, e;
    result_t         r;

    xor_store[load_count] = d ^ s;
    if (!l && load_count < 15) begin
      load_count++;
      return;
    end
    for (int i = load_count + 1; i < 16; i++) xor_store[i] = '0;
    for (int i = 0; i < 16; i++) m[DIAG[i]] = xor_store[i];
    for (int rnd = 0; rnd < int'(round_setting); rnd++) begin
      for (int q = 0; q < 8; q++) begin
        a = QLANE[q][0];
        b = QLANE[q][1];
        c = QLANE[q][2];
        e = QLANE[q][3];
        m[b] ^= rotl(m[a] + m[e], 7);
        m[c] ^= rotl(m[b] + m[a], 9);
        m[e] ^= rotl(m[c] + m[b], 13);
        m[a] ^= rotl(m[e] + m[c], 18);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (typed) r.word = (i == 0) ? typed0 : '0;
      else r.word = xor_store[i] + m[DIAG[i]];
      r.last = (i == 15);
      block_results.push_back(r);
    end
    load_count = 0;
    blocks_done++;
  endtask

  // Offers one word pair after a random gap and waits for its transaction.
  task automatic send_word(input s20x_pkg::word_t d, input s20x_pkg::word_t s,
                           input logic l, input bit typed,
                           input s20x_pkg::word_t typed0);
    int gap;

    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.dst_word <= d;
    in_if.src_word <= s;
    in_if.last_in  <= l;
    do @(posedge clk); while (!in_if.ready);
    absorb_word(d, s, l, typed, typed0);
    words_loaded++;
  endtask

  // Stops offering, waits for every queued result, then lets the core settle.
  task automatic wait_block_idle(input int extra);
    in_if.valid <= 1'b0;
    while (block_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_round_count(input s20x_pkg::drc_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    round_setting = v;
    settings_seen[v] = 1'b1;
  endtask

  // Stimulus: reset, the directed table, then random phases.
  initial begin
    int      random_words;
    int      phase;
    int      nblocks;
    int      shape;
    stim_row_t row;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.dst_word <= '0;
    in_if.src_word <= '0;
    in_if.last_in  <= 1'b0;
    round_setting  = s20x_pkg::DRC_RESET;
    settings_seen  = '0;
    load_count     = 0;
    sender_gap_max = 7;
    receiver_stall_max = 7;
    hold_outputs_request = 1'b0;

    // After reset the count is four; an all-zero block stays all zero.
    directed_rows[0] = '{1'b0, 4'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h0};
    // With no rounds every result is twice the stored word.
    directed_rows[1] = '{1'b1, 4'd0, 32'h12345678, 32'h0, 1'b1, 1'b1, 32'h2468ACF0};
    directed_rows[2] = '{1'b0, 4'd0, 32'hFFFFFFFF, 32'h0, 1'b1, 1'b1, 32'hFFFFFFFE};
    // Short block of three words under one double round.
    directed_rows[3] = '{1'b1, 4'd1, 32'hFFFFFFFF, 32'h0, 1'b0, 1'b0, 32'h0};
    directed_rows[4] = '{1'b0, 4'd0, 32'h80000000, 32'h00000001, 1'b0, 1'b0, 32'h0};
    directed_rows[5] = '{1'b0, 4'd0, 32'h0, 32'hAAAAAAAA, 1'b1, 1'b0, 32'h0};
    // Full block that completes on its sixteenth word without last_in.
    for (int i = 6; i < 22; i++)
      directed_rows[i] = '{i == 6, 4'd10, 32'h9E3779B9 * (i - 5),
                           ~(32'h1 << (i - 6)), 1'b0, 1'b0, 32'h0};
    // Largest round count.
    directed_rows[22] = '{1'b1, 4'd15, 32'h5555AAAA, 32'h0F0F0F0F, 1'b1, 1'b0, 32'h0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    settings_seen[s20x_pkg::DRC_RESET] = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.do_cfg) begin
        wait_block_idle(IDLE_GAP);
        write_round_count(row.cfg_val);
      end
      send_word(row.dst, row.src, row.last, row.typed, row.typed0);
    end

    // Random phases, each after a round count write and with its own idling mix.
    random_words = 0;
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      wait_block_idle(IDLE_GAP);
      if (phase == 0) write_round_count(4'd15);
      else if (phase == 1) write_round_count(4'd0);
      else write_round_count(s20x_pkg::drc_t'($urandom_range(0, 15)));
      sender_gap_max     = ($urandom_range(0, 2) == 0) ? 0 : 7;
      receiver_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      nblocks = $urandom_range(1, 2);
      // One phase holds the output back while the sender keeps offering.
      if (phase == 2) begin
        hold_outputs_request = 1'b1;
        sender_gap_max = 0;
        nblocks = 2;
      end
      for (int b = 0; b < nblocks; b++) begin
        shape = $urandom_range(0, 9);
        if (shape <= 7) begin
          // Well-formed full block; some omit last_in on the final word.
          for (int k = 0; k < 16; k++) begin
            send_word(rand_word(), rand_word(), (k == 15) && (shape <= 5), 1'b0, '0);
            random_words++;
          end
        end else begin
          // Random last_in flags until the block closes.
          do begin
            send_word(rand_word(), rand_word(), $urandom_range(0, 3) == 0, 1'b0, '0);
            random_words++;
          end while (load_count != 0);
        end
      end
      phase++;
    end

    wait_block_idle(DRAIN_CYCLES);
    $display("Run covered %0d word pairs in %0d blocks, %0d result words checked.",
             words_loaded, blocks_done, results_checked);
    $display("Round counts used (bit mask): %h; long output holds: %0d.",
             settings_seen, holds_done);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls, one long hold, and a check on every transaction.
  initial begin
    int      stall;
    result_t want;

    out_if.ready    <= 1'b0;
    error_count     = 0;
    results_checked = 0;
    holds_done      = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = $urandom_range(0, receiver_stall_max);
      if (hold_outputs_request) begin
        hold_outputs_request = 1'b0;
        stall = LONG_HOLD;
        holds_done++;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      results_checked++;
      if (block_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("Unexpected result transaction: word %h last %b",
                   out_if.out_word, out_if.last_out);
        error_count++;
      end else begin
        want = block_results.pop_front();
        if (out_if.out_word !== want.word || out_if.last_out !== want.last) begin
          if (error_count < MAX_REPORTS)
            $display("Mismatch on result %0d: expected word %h last %b, got word %h last %b",
                     results_checked, want.word, want.last, out_if.out_word,
                     out_if.last_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results still pending.",
               idle_cycles, block_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
